FILE: rtl/core/dcop_pkg.sv
// ----------------------------------------------------------------------------
// dcop_pkg: shared definitions for the output-pixel convolution engine
// Field widths, command and register codes, parameter defaults and the
// control word passed to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package dcop_pkg;

    // Parameter defaults.
    localparam int DEF_FEATURE_DEPTH    = 4096;
    localparam int DEF_WEIGHT_DEPTH     = 4096;
    localparam int DEF_MAX_OUT_CHANNELS = 64;
    localparam int DEF_DATA_WIDTH       = 16;

    // Word fields.
    localparam int ADDR_W     = 12;
    localparam int VALUE_W    = 16;
    localparam int CH_W       = 6;
    localparam int POS_W      = 8;
    localparam int ACC_W      = 48;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 9;

    // Internal widths.
    localparam int CNT_W  = 5;   // channel and tap counters
    localparam int POSN_W = 15;  // signed input row or column of a tap
    localparam int RB_W   = 26;  // signed linear feature index
    localparam int WI_W   = 22;  // linear weight index

    typedef enum logic [1:0] {
        CMD_LOAD_FEATURE = 2'd0,
        CMD_LOAD_WEIGHT  = 2'd1,
        CMD_LOAD_BIAS    = 2'd2,
        CMD_COMPUTE      = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_CHANNELS = 4'd0,
        CFG_IN_HEIGHT   = 4'd1,
        CFG_IN_WIDTH    = 4'd2,
        CFG_KERN_HEIGHT = 4'd3,
        CFG_KERN_WIDTH  = 4'd4,
        CFG_STRIDE_HW   = 4'd5,
        CFG_PAD_HW      = 4'd6,
        CFG_DILATION_HW = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic init;    // load the accumulator with the bias
        logic tap_v;   // operands of one tap are on the inputs
        logic tap_ok;  // the tap lies inside the image and the stores
    } t_mac_ctl;

endpackage

FILE: rtl/core/dcop_ifs.sv
// ----------------------------------------------------------------------------
// dcop channel interfaces
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface dcop_cmd_if;
    import dcop_pkg::*;
    logic                      valid;
    logic                      ready;
    t_cmd                      command;
    logic [ADDR_W-1:0]         store_address;
    logic signed [VALUE_W-1:0] load_value;
    logic [CH_W-1:0]           out_channel;
    logic [POS_W-1:0]          out_row;
    logic [POS_W-1:0]          out_col;

    modport source (
        output valid, command, store_address, load_value, out_channel, out_row, out_col,
        input  ready
    );
    modport sink (
        input  valid, command, store_address, load_value, out_channel, out_row, out_col,
        output ready
    );
endinterface

interface dcop_res_if;
    import dcop_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] result_value;
    logic [CH_W-1:0]         res_channel;
    logic [POS_W-1:0]        res_row;
    logic [POS_W-1:0]        res_col;

    modport source (
        output valid, result_value, res_channel, res_row, res_col,
        input  ready
    );
    modport sink (
        input  valid, result_value, res_channel, res_row, res_col,
        output ready
    );
endinterface

interface dcop_cfg_if;
    import dcop_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/dcop_mac.sv
// ----------------------------------------------------------------------------
// dcop_mac: multiply-accumulate unit
// Registers the product of one sample and one weight per cycle and adds it
// into a 48-bit Q32.16 accumulator that starts from the channel bias.
// ----------------------------------------------------------------------------
module dcop_mac #(
    parameter int DATA_WIDTH = dcop_pkg::DEF_DATA_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dcop_pkg::t_mac_ctl               i_ctl,
    input  logic signed [DATA_WIDTH-1:0]     i_feature,
    input  logic signed [DATA_WIDTH-1:0]     i_weight,
    input  logic signed [dcop_pkg::ACC_W-1:0] i_bias,
    output logic signed [dcop_pkg::ACC_W-1:0] o_acc,
    output logic                             o_busy
);
    import dcop_pkg::*;

    logic signed [2*DATA_WIDTH-1:0] r_prod;
    logic                           r_prod_v;
    logic signed [ACC_W-1:0]        r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_ctl.tap_v;
        end
    end

    // A tap outside the image contributes zero.
    always_ff @(posedge i_clk) begin
        if (i_ctl.tap_ok) begin
            r_prod <= i_feature * i_weight;
        end else begin
            r_prod <= '0;
        end
        if (i_ctl.init) begin
            r_acc <= i_bias;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_prod_v;

`ifndef SYNTHESIS
    a_init_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.init |-> !r_prod_v && !i_ctl.tap_v)
        else $error("accumulator initialized with products in flight");
`endif

endmodule

FILE: rtl/core/direct_conv2d_output_pixel_top.sv
// ----------------------------------------------------------------------------
// direct_conv2d_output_pixel_top: direct 2D convolution, one output pixel
// Sample, weight and bias stores with a sequenced multiply-accumulate loop.
// ----------------------------------------------------------------------------
// Load words write one entry of the sample, weight or bias store, and the
// block stays ready for the next word. A compute word runs through every input
// channel and kernel tap, one tap per cycle through the single read port of
// each store, between the setup steps and a drain step, before the block
// can accept the next word; the result then waits in an output register
// while the block goes on. Taps outside the image add zero. After reset the
// bias store is swept to zero one entry at a time, and no command word is
// accepted during the sweep; configuration words are taken at any time and must
// only be written while the block is idle.
// ----------------------------------------------------------------------------
module direct_conv2d_output_pixel_top #(
    parameter int FEATURE_DEPTH    = dcop_pkg::DEF_FEATURE_DEPTH,
    parameter int WEIGHT_DEPTH     = dcop_pkg::DEF_WEIGHT_DEPTH,
    parameter int MAX_OUT_CHANNELS = dcop_pkg::DEF_MAX_OUT_CHANNELS,
    parameter int DATA_WIDTH       = dcop_pkg::DEF_DATA_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dcop_cmd_if.sink     i_cmd,
    dcop_cfg_if.sink     i_cfg,
    dcop_res_if.source   o_res
);
    import dcop_pkg::*;

    localparam int FA_W = $clog2(FEATURE_DEPTH);
    localparam int WA_W = $clog2(WEIGHT_DEPTH);
    localparam int BA_W = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_SETUP0, ST_SETUP1, ST_SETUP2, ST_RUN, ST_DRAIN
    } t_state;

    // Configuration registers.
    logic [4:0] r_in_ch, r_kh, r_kw;
    logic [8:0] r_in_h, r_in_w;
    logic [7:0] r_stride, r_pad, r_dil;

    // Stores.
    logic signed [DATA_WIDTH-1:0] feature_mem [FEATURE_DEPTH];
    logic signed [DATA_WIDTH-1:0] weight_mem [WEIGHT_DEPTH];
    logic signed [DATA_WIDTH-1:0] bias_mem [MAX_OUT_CHANNELS];
    logic signed [DATA_WIDTH-1:0] r_feat_q, r_wgt_q, r_bias_q;

    // Sequencer state.
    t_state                   r_state;
    logic [BA_W-1:0]          r_clr_idx;
    logic [CH_W-1:0]          r_oc;
    logic [POS_W-1:0]         r_row, r_col;
    logic signed [POSN_W-1:0] r_h0, r_w0, r_h, r_w;
    logic [9:0]               r_taps;
    logic [17:0]              r_plane;
    logic signed [24:0]       r_h0w;
    logic [12:0]              r_dvw;
    logic [14:0]              r_ct;
    logic [CNT_W-1:0]         r_c, r_kr, r_kc;
    logic signed [RB_W-1:0]   r_chan_base, r_row_base;
    logic [WI_W-1:0]          r_widx;
    logic                     r_p1, r_tap_ok1;

    // Result register.
    logic                    r_out_valid;
    logic signed [ACC_W-1:0] r_out_value;
    logic [CH_W-1:0]         r_out_ch;
    logic [POS_W-1:0]        r_out_row, r_out_col;

    logic                         w_accept;
    logic signed [DATA_WIDTH-1:0] w_load_data;
    logic                         w_fe_we, w_wt_we, w_bi_we, w_oc_ok;
    logic [11:0]                  w_row_sv, w_col_sh;
    logic [20:0]                  w_wbase;
    logic signed [RB_W-1:0]       w_fi, w_next_chan;
    logic                         w_h_ok, w_w_ok, w_tap_ok, w_empty;
    logic                         w_last_kc, w_last_kr, w_last_c, w_drained, w_out_free;
    logic signed [ACC_W-1:0]      w_bias_q16, w_acc;
    logic                         w_mac_busy;
    t_mac_ctl                     w_mac_ctl;

    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_load_data = DATA_WIDTH'(i_cmd.load_value);

    assign w_fe_we = w_accept && (i_cmd.command == CMD_LOAD_FEATURE)
                   && ({20'b0, i_cmd.store_address} < 32'(FEATURE_DEPTH));
    assign w_wt_we = w_accept && (i_cmd.command == CMD_LOAD_WEIGHT)
                   && ({20'b0, i_cmd.store_address} < 32'(WEIGHT_DEPTH));
    assign w_bi_we = w_accept && (i_cmd.command == CMD_LOAD_BIAS)
                   && ({20'b0, i_cmd.store_address} < 32'(MAX_OUT_CHANNELS));
    assign w_oc_ok = ({26'b0, r_oc} < 32'(MAX_OUT_CHANNELS));

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ch  <= 5'd1;
            r_in_h   <= 9'd1;
            r_in_w   <= 9'd1;
            r_kh     <= 5'd1;
            r_kw     <= 5'd1;
            r_stride <= 8'h11;
            r_pad    <= 8'h00;
            r_dil    <= 8'h11;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_IN_CHANNELS: r_in_ch  <= i_cfg.data[4:0];
                CFG_IN_HEIGHT:   r_in_h   <= i_cfg.data[8:0];
                CFG_IN_WIDTH:    r_in_w   <= i_cfg.data[8:0];
                CFG_KERN_HEIGHT: r_kh     <= i_cfg.data[4:0];
                CFG_KERN_WIDTH:  r_kw     <= i_cfg.data[4:0];
                CFG_STRIDE_HW:   r_stride <= i_cfg.data[7:0];
                CFG_PAD_HW:      r_pad    <= i_cfg.data[7:0];
                CFG_DILATION_HW: r_dil    <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Stores: loads write while idle, the tap loop reads one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (w_fe_we) begin
            feature_mem[FA_W'(i_cmd.store_address)] <= w_load_data;
        end
        if (r_state == ST_RUN) begin
            r_feat_q <= feature_mem[FA_W'(w_fi)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wt_we) begin
            weight_mem[WA_W'(i_cmd.store_address)] <= w_load_data;
        end
        if (r_state == ST_RUN) begin
            r_wgt_q <= weight_mem[WA_W'(r_widx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            bias_mem[r_clr_idx] <= '0;
        end else if (w_bi_we) begin
            bias_mem[BA_W'(i_cmd.store_address)] <= w_load_data;
        end
        if (r_state == ST_SETUP0) begin
            r_bias_q <= bias_mem[BA_W'(r_oc)];
        end
    end

    // Tap position and store indexes.
    assign w_row_sv    = r_row * r_stride[3:0];
    assign w_col_sh    = r_col * r_stride[7:4];
    assign w_wbase     = r_oc * r_ct;
    assign w_fi        = r_row_base + RB_W'(r_w);
    assign w_next_chan = r_chan_base + $signed({8'b0, r_plane});
    assign w_h_ok      = !r_h[POSN_W-1] && (r_h < $signed({6'b0, r_in_h}));
    assign w_w_ok      = !r_w[POSN_W-1] && (r_w < $signed({6'b0, r_in_w}));
    assign w_tap_ok    = w_h_ok && w_w_ok && (w_fi < RB_W'(FEATURE_DEPTH))
                       && (r_widx < WI_W'(WEIGHT_DEPTH));
    assign w_empty     = (r_in_ch == 5'd0) || (r_kh == 5'd0) || (r_kw == 5'd0);
    assign w_last_kc   = (r_kc == r_kw - 5'd1);
    assign w_last_kr   = (r_kr == r_kh - 5'd1);
    assign w_last_c    = (r_c == r_in_ch - 5'd1);
    assign w_drained   = !r_p1 && !w_mac_busy;
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_bias_q16  = w_oc_ok ? (ACC_W'(r_bias_q) <<< 8) : '0;

    assign w_mac_ctl.init   = (r_state == ST_SETUP2);
    assign w_mac_ctl.tap_v  = r_p1;
    assign w_mac_ctl.tap_ok = r_tap_ok1;

    dcop_mac #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_mac_ctl),
        .i_feature (r_feat_q),
        .i_weight  (r_wgt_q),
        .i_bias    (w_bias_q16),
        .o_acc     (w_acc),
        .o_busy    (w_mac_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_p1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1 <= (r_state == ST_RUN);
            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == BA_W'(MAX_OUT_CHANNELS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept && (i_cmd.command == CMD_COMPUTE)) begin
                        r_oc    <= i_cmd.out_channel;
                        r_row   <= i_cmd.out_row;
                        r_col   <= i_cmd.out_col;
                        r_state <= ST_SETUP0;
                    end
                end
                ST_SETUP0: begin
                    r_h0    <= $signed({3'b0, w_row_sv}) - $signed({11'b0, r_pad[3:0]});
                    r_w0    <= $signed({3'b0, w_col_sh}) - $signed({11'b0, r_pad[7:4]});
                    r_taps  <= r_kh * r_kw;
                    r_plane <= r_in_h * r_in_w;
                    r_state <= ST_SETUP1;
                end
                ST_SETUP1: begin
                    r_h0w   <= r_h0 * $signed({1'b0, r_in_w});
                    r_dvw   <= r_dil[3:0] * r_in_w;
                    r_ct    <= r_in_ch * r_taps;
                    r_state <= ST_SETUP2;
                end
                ST_SETUP2: begin
                    r_widx      <= {1'b0, w_wbase};
                    r_c         <= '0;
                    r_kr        <= '0;
                    r_kc        <= '0;
                    r_h         <= r_h0;
                    r_w         <= r_w0;
                    r_chan_base <= '0;
                    r_row_base  <= RB_W'(r_h0w);
                    r_state     <= w_empty ? ST_DRAIN : ST_RUN;
                end
                ST_RUN: begin
                    r_tap_ok1 <= w_tap_ok;
                    r_widx    <= r_widx + 1'b1;
                    if (!w_last_kc) begin
                        r_kc <= r_kc + 1'b1;
                        r_w  <= r_w + $signed({11'b0, r_stride[7:4] & 4'h0 | r_dil[7:4]});
                    end else begin
                        r_kc <= '0;
                        r_w  <= r_w0;
                        if (!w_last_kr) begin
                            r_kr       <= r_kr + 1'b1;
                            r_h        <= r_h + $signed({11'b0, r_dil[3:0]});
                            r_row_base <= r_row_base + $signed({13'b0, r_dvw});
                        end else begin
                            r_kr        <= '0;
                            r_h         <= r_h0;
                            r_c         <= r_c + 1'b1;
                            r_chan_base <= w_next_chan;
                            r_row_base  <= w_next_chan + RB_W'(r_h0w);
                            if (w_last_c) begin
                                r_state <= ST_DRAIN;
                            end
                        end
                    end
                end
                ST_DRAIN: begin
                    if (w_drained && w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= w_acc;
                        r_out_ch    <= r_oc;
                        r_out_row   <= r_row;
                        r_out_col   <= r_col;
                        r_state     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.result_value = r_out_value;
    assign o_res.res_channel  = r_out_ch;
    assign o_res.res_row      = r_out_row;
    assign o_res.res_col      = r_out_col;

`ifndef SYNTHESIS
    a_tap_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1 |-> $past(r_state == ST_RUN))
        else $error("tap in flight without a loop step");
    a_widx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |=> (r_widx == $past(r_widx) + 1'b1))
        else $error("weight index did not advance by one per tap");
    a_result_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DRAIN))
        else $error("result loaded outside the drain step");
    a_init_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_ctl.init |-> !r_p1 && !w_mac_busy)
        else $error("bias loaded while products are in flight");
`endif

endmodule
